@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the sliding window maximum block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define AST_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define AST_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/swm_pkg.sv @@
// Package for the sliding window maximum block: sizes, sequencer states.
// No dependencies.
`default_nettype none

package swm_pkg;

  localparam int WinMax  = 64;                  // largest window
  localparam int SampleW = 32;                  // sample width
  localparam int CfgW    = 7;                   // window_size register width
  localparam int PtrW    = $clog2(WinMax);      // ring pointer
  localparam int PosW    = $clog2(2 * WinMax);  // positions wrap mod 2*WinMax
  localparam int CntW    = $clog2(WinMax + 1);  // occupancy, seen count
  localparam int EntryW  = PosW + SampleW;      // {position, value}
  localparam logic [CfgW-1:0] WinReset = CfgW'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CHK,
    ST_BACK_RD,
    ST_BACK_CHK,
    ST_PUSH
  } state_e;

endpackage

`default_nettype wire

@@ rtl/core/swm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_maximum_top.sv @@
// Sliding window maximum top level: monotonic deque in a RAM, walked by a sequencer.
// Depends on swm_pkg, swm_ram and assert_macros.svh.
//
// Channel   Dir  Signals                          Contents
// s_axis    in   tvalid tready tdata[31:0] tuser  sample; tuser[0] = first of sequence
// m_axis    out  tvalid tready tdata[31:0]        window_max
// cfg       in   cfg_we_i cfg_wdata_i[6:0]        window_size
//
// One transaction at a time. Steps per item: accept, front phase, back phase, push.
// Each phase issues a read and then checks the entry, for each entry examined, plus a
// final read when it ends on an empty deque; an item on an empty deque only accepts,
// reads front, reads back and pushes. The single read port of the deque RAM sets this
// pace. No clearing pass after reset: pointers and counts reset, RAM contents are only
// read after being written in the same sequence.
// A push that emits a result waits while a previous result is still held, untaken, in the output register.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_maximum_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input samples
  input  wire logic                        s_axis_tvalid,
  output      logic                        s_axis_tready,
  input  wire logic [swm_pkg::SampleW-1:0] s_axis_tdata,  // [31:0] sample
  input  wire logic [0:0]                  s_axis_tuser,  // [0] first
  // results
  output      logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output      logic [swm_pkg::SampleW-1:0] m_axis_tdata,  // [31:0] window_max
  // configuration
  input  wire logic                        cfg_we_i,
  input  wire logic [swm_pkg::CfgW-1:0]    cfg_wdata_i
);

  swm_pkg::state_e state_q, state_d;

  logic [swm_pkg::SampleW-1:0] sample_q, sample_d;
  logic [swm_pkg::SampleW-1:0] front_q, front_d;   // head value seen in front phase
  logic [swm_pkg::PtrW-1:0]    head_q, head_d;
  logic [swm_pkg::PtrW-1:0]    tail_q, tail_d;
  logic [swm_pkg::CntW-1:0]    occ_q, occ_d;
  logic [swm_pkg::PosW-1:0]    pos_q, pos_d;
  logic [swm_pkg::CntW-1:0]    seen_q, seen_d;
  logic [swm_pkg::CfgW-1:0]    win_q;
  logic                        out_valid_q, out_valid_d;
  logic [swm_pkg::SampleW-1:0] out_data_q, out_data_d;

  // deque RAM port signals
  logic                        ram_we;
  logic [swm_pkg::PtrW-1:0]    ram_raddr;
  logic [swm_pkg::EntryW-1:0]  ram_rdata;
  logic [swm_pkg::SampleW-1:0] rd_val;
  logic [swm_pkg::PosW-1:0]    rd_pos;

  logic [swm_pkg::CfgW-1:0]    win_eff;
  logic [swm_pkg::PosW-1:0]    age;
  logic [swm_pkg::CntW-1:0]    seen_inc;
  logic                        emit;
  logic                        s_accept;

  assign rd_val   = ram_rdata[swm_pkg::SampleW-1:0];
  assign rd_pos   = ram_rdata[swm_pkg::EntryW-1:swm_pkg::SampleW];
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // Window size zero acts as one, oversize saturates.
  always_comb begin
    if (win_q == '0) begin
      win_eff = swm_pkg::CfgW'(1);
    end else if (win_q > swm_pkg::CfgW'(swm_pkg::WinMax)) begin
      win_eff = swm_pkg::CfgW'(swm_pkg::WinMax);
    end else begin
      win_eff = win_q;
    end
  end

  assign age      = pos_q - rd_pos;  // wraps mod 2*WinMax
  assign seen_inc = (seen_q < swm_pkg::CntW'(swm_pkg::WinMax)) ?
                    seen_q + swm_pkg::CntW'(1) : seen_q;
  assign emit     = seen_inc >= swm_pkg::CntW'(win_eff);

  swm_ram #(
    .Width (swm_pkg::EntryW),
    .Depth (swm_pkg::WinMax)
  ) u_deque (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i ({pos_q, sample_q}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    front_d     = front_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    pos_d       = pos_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_raddr   = head_q;

    s_axis_tready = (state_q == swm_pkg::ST_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      swm_pkg::ST_IDLE: begin
        if (s_accept) begin
          sample_d = s_axis_tdata;
          if (s_axis_tuser[0]) begin
            head_d = '0;
            tail_d = '0;
            occ_d  = '0;
            pos_d  = '0;
            seen_d = '0;
          end
          state_d = swm_pkg::ST_FRONT_RD;
        end
      end
      swm_pkg::ST_FRONT_RD: begin
        ram_raddr = head_q;
        state_d   = (occ_q == '0) ? swm_pkg::ST_BACK_RD : swm_pkg::ST_FRONT_CHK;
      end
      swm_pkg::ST_FRONT_CHK: begin
        // stale head leaves; otherwise remember it as the window front
        if (age >= swm_pkg::PosW'(win_eff)) begin
          head_d  = head_q + swm_pkg::PtrW'(1);
          occ_d   = occ_q - swm_pkg::CntW'(1);
          state_d = swm_pkg::ST_FRONT_RD;
        end else begin
          front_d = rd_val;
          state_d = swm_pkg::ST_BACK_RD;
        end
      end
      swm_pkg::ST_BACK_RD: begin
        ram_raddr = tail_q - swm_pkg::PtrW'(1);
        state_d   = (occ_q == '0) ? swm_pkg::ST_PUSH : swm_pkg::ST_BACK_CHK;
      end
      swm_pkg::ST_BACK_CHK: begin
        // strictly smaller entries go, equal ones stay
        if ($signed(rd_val) < $signed(sample_q)) begin
          tail_d  = tail_q - swm_pkg::PtrW'(1);
          occ_d   = occ_q - swm_pkg::CntW'(1);
          state_d = swm_pkg::ST_BACK_RD;
        end else begin
          state_d = swm_pkg::ST_PUSH;
        end
      end
      swm_pkg::ST_PUSH: begin
        // deque never full here: stale entries were dropped above
        if (!(emit && out_valid_q && !m_axis_tready)) begin
          ram_we = 1'b1;
          tail_d = tail_q + swm_pkg::PtrW'(1);
          occ_d  = occ_q + swm_pkg::CntW'(1);
          pos_d  = pos_q + swm_pkg::PosW'(1);
          seen_d = seen_inc;
          if (emit) begin
            out_valid_d = 1'b1;
            out_data_d  = (occ_q == '0) ? sample_q : front_q;
          end
          state_d = swm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = swm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swm_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      pos_q       <= '0;
      seen_q      <= '0;
      win_q       <= swm_pkg::WinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    front_q    <= front_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // occupancy matches the ring pointers and never exceeds the ring
  `AST_HOLDS(a_occ_ptrs, clk_i, rst_ni,
             occ_q[swm_pkg::PtrW-1:0] == swm_pkg::PtrW'(tail_q - head_q))
  `AST_NEVER(a_occ_max, clk_i, rst_ni, occ_q > swm_pkg::CntW'(swm_pkg::WinMax))
  // a first-of-sequence transaction starts from an empty deque at position zero
  `AST_HOLDS(a_first_clears, clk_i, rst_ni,
             (s_accept && s_axis_tuser[0]) |=> (occ_q == '0 && pos_q == '0))
  // a result is only loaded from the push step
  `AST_HOLDS(a_load_on_push, clk_i, rst_ni,
             $rose(out_valid_q) |-> ($past(state_q) == swm_pkg::ST_PUSH))

endmodule

`default_nettype wire
